[rtl/w2s_pkg.sv]
// w2s_pkg: shared widths, codes, item structs and the divider step function
// for the world-to-screen projection core.
// Depends on nothing; imported by every other file of the block.
package w2s_pkg;

  // Field and datapath widths
  localparam int VW          = 48;   // coefficient / vector entry width
  localparam int OFF_W       = 40;   // saturated offset, Q24.16
  localparam int PP_W        = 50;   // partial product width
  localparam int PROD_W      = 98;   // full product width
  localparam int ACC_W       = 100;  // row sum width
  localparam int DIV_BITS    = 32;   // quotient bits, one per divider stage
  localparam int REM_W       = VW + DIV_BITS;
  localparam int HUD_W       = 32;
  localparam int IDX_W       = 6;
  localparam int IN_TDATA_W  = 200;
  localparam int OUT_TDATA_W = 64;

  // Rounding shifts of the two matrix stages
  localparam int VIEW_SH = 16;
  localparam int PROJ_SH = 24;

  // Item kinds
  localparam logic KIND_WRITE   = 1'b0;
  localparam logic KIND_PROJECT = 1'b1;

  // Coefficient banks, selected by index bits [5:4]
  localparam logic [1:0] BANK_VIEW   = 2'd0;
  localparam logic [1:0] BANK_PROJ   = 2'd1;
  localparam logic [1:0] BANK_ORIGIN = 2'd2;
  localparam int         ORIGIN_CNT  = 3;

  // w = 1.0 in Q.16
  localparam logic [VW-1:0] W_ONE = VW'(65536);
  // HUD center offset, 0.5 in Q16.16
  localparam int HUD_HALF = 32768;

  // Control part of an item travelling down the pipe
  typedef struct packed {
    logic             vld;
    logic             kind;
    logic [IDX_W-1:0] idx;
    logic [VW-1:0]    val;
  } hdr_t;

  // Item with its current 4-entry vector
  typedef struct packed {
    hdr_t               hdr;
    logic [3:0][VW-1:0] vec;
  } item_t;

  // One divider lane (x or y)
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [DIV_BITS-1:0] quo;
    logic                neg;
    logic                ovf;
  } lane_t;

  // Divider item
  typedef struct packed {
    logic          vld;
    logic          front;
    logic [VW-1:0] w;
    lane_t         x;
    lane_t         y;
  } div_t;

  // Result item
  typedef struct packed {
    logic             front;
    logic [HUD_W-1:0] hx;
    logic [HUD_W-1:0] hy;
  } res_t;

  // One restoring division step
  function automatic lane_t div_step(lane_t l, logic [REM_W-1:0] dsh,
                                     logic [DIV_BITS-1:0] qbit);
    lane_t r;
    r = l;
    if (l.rem >= dsh) begin
      r.rem = l.rem - dsh;
      r.quo = l.quo | qbit;
    end
    return r;
  endfunction

endpackage

[rtl/world_to_screen_projection_core.sv]
// world_to_screen_projection_core: top level of the world-to-HUD projection.
// Depends on w2s_pkg, w2s_mat (view and projection stages), w2s_div.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+-------------------------------------
//  in_     | in  | in_tvalid/in_tready  | tuser=kind, tdata=index,value,x,y,z
//  out_    | out | out_tvalid/out_tready| tuser=in_front, tdata=hud_x,hud_y
//
// One item enters per cycle while in_tready is high; a project item passes the offset
// register, view matrix, projection matrix, divider setup register, divider and output
// register in that order. The 32-stage divider sets the depth.
// Write items take effect in stream order and give no result.
// Reset (rst_n low, synchronous) clears all coefficients and valid bits.
// A stalled output fills one skid entry; in_tready drops only while it is full.
module world_to_screen_projection_core import w2s_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // coef_index, coef_value, pos_x, pos_y, pos_z, pad
  input  logic                   in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hud_x, hud_y
  output logic                   out_tuser   // in_front
);

  localparam logic signed [VW:0] OFF_HI = (49'sd1 <<< (OFF_W - 1)) - 49'sd1;
  localparam logic signed [VW:0] OFF_LO = -(49'sd1 <<< (OFF_W - 1));

  logic             en;
  logic             kind;
  logic [IDX_W-1:0] idx;
  logic [VW-1:0]    val;
  logic [2:0][VW-1:0] pos;
  logic [VW-1:0]    origin_r [ORIGIN_CNT];
  item_t            s1_nxt, s1_r, view_out, proj_out;
  div_t             prep_nxt, prep_r, div_out;
  res_t             fin, out_r, skid_r;
  logic             out_v_r, skid_v_r, fin_v;

  // The pipe moves as a whole whenever the skid entry is free
  assign en        = !skid_v_r;
  assign in_tready = en;

  assign kind   = in_tuser;
  assign idx    = in_tdata[5:0];
  assign val    = in_tdata[53:6];
  assign pos[0] = in_tdata[101:54];
  assign pos[1] = in_tdata[149:102];
  assign pos[2] = in_tdata[197:150];

  // Camera origin, written on acceptance
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORIGIN_CNT; i++) origin_r[i] <= '0;
    end else if (en && in_tvalid && kind == KIND_WRITE && idx[5:4] == BANK_ORIGIN &&
                 idx[3:0] < 4'(ORIGIN_CNT)) begin
      origin_r[idx[1:0]] <= val;
    end
  end

  // Stage 1: offset from origin, saturated to Q24.16
  always_comb begin
    logic signed [VW:0] d;
    s1_nxt.hdr.vld  = in_tvalid;
    s1_nxt.hdr.kind = kind;
    s1_nxt.hdr.idx  = idx;
    s1_nxt.hdr.val  = val;
    for (int r = 0; r < 3; r++) begin
      d = $signed({pos[r][VW-1], pos[r]}) - $signed({origin_r[r][VW-1], origin_r[r]});
      if (d > OFF_HI)      d = OFF_HI;
      else if (d < OFF_LO) d = OFF_LO;
      s1_nxt.vec[r] = d[VW-1:0];
    end
    s1_nxt.vec[3] = W_ONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.hdr.vld <= 1'b0;
    end else if (en) begin
      s1_r <= s1_nxt;
    end
  end

  w2s_mat #(.BANK(BANK_VIEW), .ROUND_SH(VIEW_SH)) u_view (
    .clk(clk), .rst_n(rst_n), .en(en), .din(s1_r), .dout(view_out)
  );

  w2s_mat #(.BANK(BANK_PROJ), .ROUND_SH(PROJ_SH)) u_proj (
    .clk(clk), .rst_n(rst_n), .en(en), .din(view_out), .dout(proj_out)
  );

  // Divider setup: magnitude of c*2^15, sign, overflow of a 32-bit quotient
  function automatic lane_t lane_prep(logic [VW-1:0] c, logic [VW-1:0] w);
    lane_t                   l;
    logic signed [VW+14:0]   n;
    logic [VW+14:0]          m;
    n     = $signed({c, 15'b0});
    m     = c[VW-1] ? (-n) : n;
    l.rem = REM_W'(m);
    l.quo = '0;
    l.neg = c[VW-1];
    l.ovf = l.rem >= {w, {DIV_BITS{1'b0}}};
    return l;
  endfunction

  always_comb begin
    prep_nxt.vld   = proj_out.hdr.vld && proj_out.hdr.kind == KIND_PROJECT;
    prep_nxt.front = $signed(proj_out.vec[3]) > $signed(VW'(0));
    prep_nxt.w     = proj_out.vec[3];
    prep_nxt.x     = lane_prep(proj_out.vec[0], proj_out.vec[3]);
    prep_nxt.y     = lane_prep(proj_out.vec[1], proj_out.vec[3]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.vld <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  w2s_div u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .din(prep_r), .dout(div_out)
  );

  // Floor for negative quotients, add one half, saturate to 32 bits
  function automatic logic [HUD_W-1:0] hud_lane(lane_t l);
    logic signed [HUD_W+1:0] q;
    logic [HUD_W-1:0]        r;
    q = $signed({2'b00, l.quo});
    if (l.neg) begin
      q = -q;
      if (l.rem != '0) q = q - 34'sd1;
    end
    q = q + 34'(HUD_HALF);
    if (l.ovf)                         r = l.neg ? {1'b1, {(HUD_W-1){1'b0}}} : {1'b0, {(HUD_W-1){1'b1}}};
    else if (q > 34'sh0_7FFF_FFFF)     r = {1'b0, {(HUD_W-1){1'b1}}};
    else if (q < -34'sh0_8000_0000)    r = {1'b1, {(HUD_W-1){1'b0}}};
    else                               r = q[HUD_W-1:0];
    return r;
  endfunction

  always_comb begin
    fin_v     = en && div_out.vld;
    fin.front = div_out.front;
    fin.hx    = div_out.front ? hud_lane(div_out.x) : '0;
    fin.hy    = div_out.front ? hud_lane(div_out.y) : '0;
  end

  // Output register with one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= fin_v;
      end
    end else if (fin_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : fin;
    end else if (fin_v) begin
      skid_r <= fin;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.front;
  assign out_tdata  = {out_r.hy, out_r.hx};

endmodule

[rtl/w2s_mat.sv]
// w2s_mat: 4x4 matrix times 4-vector, coefficient bank included, three stages:
// partial products, products, row sums with round half up and saturation.
// Depends on w2s_pkg.
module w2s_mat import w2s_pkg::*; #(
  parameter logic [1:0] BANK     = BANK_VIEW,
  parameter int         ROUND_SH = VIEW_SH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  item_t din,
  output item_t dout
);

  localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) <<< (VW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) <<< (VW - 1));
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (ROUND_SH - 1);

  logic [VW-1:0] coef_r [16];

  logic signed [PP_W-1:0]   pp_nxt  [4][4][4];
  logic signed [PP_W-1:0]   pp_r    [4][4][4];
  logic signed [PROD_W-1:0] prod_nxt[4][4];
  logic signed [PROD_W-1:0] prod_r  [4][4];
  logic [3:0][VW-1:0]       res_nxt;
  hdr_t                     a_hdr_r, b_hdr_r;
  item_t                    dout_r;

  // Coefficient bank: a write item updates it as it passes this stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) coef_r[i] <= '0;
    end else if (en && din.hdr.vld && din.hdr.kind == KIND_WRITE &&
                 din.hdr.idx[5:4] == BANK) begin
      coef_r[din.hdr.idx[3:0]] <= din.hdr.val;
    end
  end

  // Stage A: split 48x48 products into four narrow partial products
  always_comb begin
    logic signed [PP_W-1:0] ah, al, bh, bl;
    logic [VW-1:0]          a;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        a  = coef_r[4'(r * 4 + c)];
        ah = PP_W'($signed(a[47:24]));
        al = PP_W'(a[23:0]);
        bh = PP_W'($signed(din.vec[c][47:24]));
        bl = PP_W'(din.vec[c][23:0]);
        pp_nxt[r][c][0] = ah * bh;
        pp_nxt[r][c][1] = ah * bl;
        pp_nxt[r][c][2] = al * bh;
        pp_nxt[r][c][3] = al * bl;
      end
    end
  end

  // Stage B: recombine partial products
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_nxt[r][c] = (PROD_W'(pp_r[r][c][0]) <<< 48)
                       + ((PROD_W'(pp_r[r][c][1]) + PROD_W'(pp_r[r][c][2])) <<< 24)
                       + PROD_W'(pp_r[r][c][3]);
      end
    end
  end

  // Stage C: row sum, round half up, saturate to 48 bits
  always_comb begin
    logic signed [ACC_W-1:0] acc, sh;
    for (int r = 0; r < 4; r++) begin
      acc = ACC_W'(prod_r[r][0]) + ACC_W'(prod_r[r][1])
          + ACC_W'(prod_r[r][2]) + ACC_W'(prod_r[r][3]) + RND;
      sh  = acc >>> ROUND_SH;
      if (sh > SAT_HI)      res_nxt[r] = SAT_HI[VW-1:0];
      else if (sh < SAT_LO) res_nxt[r] = SAT_LO[VW-1:0];
      else                  res_nxt[r] = sh[VW-1:0];
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_hdr_r.vld    <= 1'b0;
      b_hdr_r.vld    <= 1'b0;
      dout_r.hdr.vld <= 1'b0;
    end else if (en) begin
      a_hdr_r    <= din.hdr;
      b_hdr_r    <= a_hdr_r;
      dout_r.hdr <= b_hdr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r       <= pp_nxt;
      prod_r     <= prod_nxt;
      dout_r.vec <= res_nxt;
    end
  end

  assign dout = dout_r;

endmodule

[rtl/w2s_div.sv]
// w2s_div: pipelined restoring divider, one quotient bit per stage,
// two lanes (x and y) sharing the divisor w.
// Depends on w2s_pkg.
module w2s_div import w2s_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  div_t st_r [DIV_BITS];

  for (genvar k = 0; k < DIV_BITS; k++) begin : g_stage
    localparam int BITPOS = DIV_BITS - 1 - k;
    div_t             prev, nxt;
    logic [REM_W-1:0] dsh;

    if (k == 0) begin : g_first
      assign prev = din;
    end else begin : g_next
      assign prev = st_r[k-1];
    end

    // Compare and subtract w shifted to this quotient bit
    always_comb begin
      dsh   = REM_W'(prev.w) << BITPOS;
      nxt   = prev;
      nxt.x = div_step(prev.x, dsh, DIV_BITS'(1) << BITPOS);
      nxt.y = div_step(prev.y, dsh, DIV_BITS'(1) << BITPOS);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_r[k].vld <= 1'b0;
      end else if (en) begin
        st_r[k] <= nxt;
      end
    end
  end

  assign dout = st_r[DIV_BITS-1];

endmodule

[rtl/w2s_chk.sv]
// w2s_chk: port-level checks for world_to_screen_projection_core, bound in below.
// Depends on w2s_pkg and the core's port list.
module w2s_chk import w2s_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A point behind the camera reports zero coordinates
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("behind-camera item with nonzero coordinates");

  // Input backpressure only while a result is waiting
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no pending result");

  // Skid entry drains once the output is taken
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && out_tready |=> in_tready)
    else $error("input still stalled after result was taken");

endmodule

bind world_to_screen_projection_core w2s_chk u_w2s_chk (.*);
